// ----- src/assert_macros.svh -----
// assertion macros shared by the comment stripper rtl
// no dependencies; taken in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccs assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define CCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccs assertion failed: next-cycle implication");

`endif

// ----- src/ccs_pkg.sv -----
// types, character codes and per-byte lexer functions of the comment stripper
// no dependencies
package ccs_pkg;

   typedef enum logic [1:0] {
      MODE_CODE    = 2'd0,
      MODE_STRING  = 2'd1,
      MODE_CHAR    = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      LA_NONE      = 2'd0,
      LA_BACKSLASH = 2'd1,
      LA_SLASH     = 2'd2,
      LA_STAR      = 2'd3
   } lookahead_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;

   // outcome of handling one byte; the emitted byte is always the byte itself
   typedef struct packed {
      mode_type      mode;
      lookahead_type la;
      logic          emit;
   } disp_type;

   // results of one item toward the output queue
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data0;
      logic [7:0] data1;
   } wr_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } entry_type;

   // handle a byte by mode, no backslash check
   function automatic disp_type dispatch(mode_type mode, logic [7:0] c);
      disp_type r;
      r.mode = mode;
      r.la   = LA_NONE;
      r.emit = 1'b0;
      case (mode)
         MODE_CODE: begin
            if (c == CH_SLASH) begin
               r.la = LA_SLASH;
            end else begin
               if (c == CH_DQUOTE) r.mode = MODE_STRING;
               else if (c == CH_SQUOTE) r.mode = MODE_CHAR;
               r.emit = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == CH_DQUOTE) r.mode = MODE_CODE;
            r.emit = 1'b1;
         end
         MODE_CHAR: begin
            if (c == CH_SQUOTE) r.mode = MODE_CODE;
            r.emit = 1'b1;
         end
         default: begin
            if (c == CH_STAR) r.la = LA_STAR;
         end
      endcase
      return r;
   endfunction

   // full handling of a byte when nothing is pending
   function automatic disp_type take(mode_type mode, logic [7:0] c);
      disp_type r;
      r = dispatch(mode, c);
      if (mode != MODE_COMMENT && c == CH_BACKSLASH) begin
         r.mode = mode;
         r.la   = LA_BACKSLASH;
         r.emit = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- src/ccs_if.sv -----
// valid/ready channel interfaces for the comment stripper
// uses nothing but plain logic types
interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- src/ccs_step.sv -----
// next lexical state and result bytes for one input item
// depends on ccs_pkg
module ccs_step (
   input  ccs_pkg::mode_type      mode_i,
   input  ccs_pkg::lookahead_type la_i,
   input  logic [7:0]             byte_i,
   input  logic                   eot_i,
   output ccs_pkg::mode_type      mode_o,
   output ccs_pkg::lookahead_type la_o,
   output ccs_pkg::wr_type        wr_o
);

   ccs_pkg::disp_type tk;
   ccs_pkg::disp_type dp;

   assign tk = ccs_pkg::take(mode_i, byte_i);
   assign dp = ccs_pkg::dispatch(mode_i, byte_i);

   always_comb begin
      mode_o     = mode_i;
      la_o       = ccs_pkg::LA_NONE;
      wr_o.count = 2'd0;
      wr_o.data0 = byte_i;
      wr_o.data1 = byte_i;
      if (eot_i) begin
         // flush a pending backslash or slash, drop a pending star
         mode_o = ccs_pkg::MODE_CODE;
         if (la_i == ccs_pkg::LA_BACKSLASH) begin
            wr_o.count = 2'd1;
            wr_o.data0 = ccs_pkg::CH_BACKSLASH;
         end else if (la_i == ccs_pkg::LA_SLASH) begin
            wr_o.count = 2'd1;
            wr_o.data0 = ccs_pkg::CH_SLASH;
         end
      end else begin
         case (la_i)
            ccs_pkg::LA_NONE: begin
               mode_o     = tk.mode;
               la_o       = tk.la;
               wr_o.count = {1'b0, tk.emit};
            end
            ccs_pkg::LA_BACKSLASH: begin
               wr_o.data0 = ccs_pkg::CH_BACKSLASH;
               if (byte_i == ccs_pkg::CH_SQUOTE || byte_i == ccs_pkg::CH_DQUOTE) begin
                  wr_o.count = 2'd2;
               end else begin
                  mode_o     = dp.mode;
                  la_o       = dp.la;
                  wr_o.count = dp.emit ? 2'd2 : 2'd1;
               end
            end
            ccs_pkg::LA_SLASH: begin
               if (byte_i == ccs_pkg::CH_STAR) begin
                  mode_o = ccs_pkg::MODE_COMMENT;
               end else begin
                  wr_o.data0 = ccs_pkg::CH_SLASH;
                  mode_o     = tk.mode;
                  la_o       = tk.la;
                  wr_o.count = tk.emit ? 2'd2 : 2'd1;
               end
            end
            default: begin
               // star pending inside a comment
               if (byte_i == ccs_pkg::CH_SLASH) begin
                  mode_o = ccs_pkg::MODE_CODE;
               end else begin
                  mode_o     = tk.mode;
                  la_o       = tk.la;
                  wr_o.count = {1'b0, tk.emit};
               end
            end
         endcase
      end
   end

endmodule

// ----- src/ccs_out_fifo.sv -----
// four-entry result queue, up to two writes and one read per cycle
// depends on ccs_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccs_out_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  ccs_pkg::wr_type wr,
   output logic            room,
   output logic            rd_valid,
   input  logic            rd_ready,
   output logic [7:0]      rd_data,
   output logic            rd_last
);

   ccs_pkg::entry_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_n;
   logic       pop;

   assign wr_n     = wr_en ? wr.count : 2'd0;
   assign rd_valid = (count_ff != 3'd0);
   assign pop      = rd_valid && rd_ready;
   assign room     = (count_ff <= 3'd2);
   assign rd_data  = mem_ff[rd_ptr_ff].data;
   assign rd_last  = mem_ff[rd_ptr_ff].last;

   assign wr_ptr_in = wr_ptr_ff + wr_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, wr_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= '{data: wr.data0, last: (wr_n == 2'd1)};
      end
      if (wr_n == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= '{data: wr.data1, last: 1'b1};
      end
   end

   `CCS_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= 3'd4)
   `CCS_ASSERT_IMPL(a_no_overflow, clock, reset, wr_n != 2'd0, room)
   `CCS_ASSERT_NEXT(a_count_track, clock, reset, 1'b1, count_ff == $past(count_in))

endmodule

// ----- src/c_comment_stripper.sv -----
// c_comment_stripper: top level, input stage, lexer state and result queue
// depends on ccs_pkg, ccs_if, ccs_step, ccs_out_fifo and assert_macros.svh
//
// usage
//   req_chan carries one source byte per transfer (in_byte) or, with
//   end_of_text high, the end of a stream; in_byte is ignored then
//   rsp_chan carries the text with block comments removed, one byte per
//   transfer; last_of_run marks the final byte caused by one request
//   a request causes zero, one or two response bytes
// path
//   a taken request waits in the input stage register until the queue has
//   room, then its decoded bytes are written to the queue, which offers them
// throughput
//   one request per cycle while the response side is ready and requests give
//   at most one byte each; the two bytes of one request leave one after the
//   other, since the response side moves one byte per cycle
// reset
//   synchronous, active high: lexer back to code mode, no look-ahead,
//   input stage and response queue empty
// stalls
//   a stalled response side fills the four-entry queue; the input stage
//   waits while fewer than two entries are free and req_chan.ready drops
//   once the stage is also full; no byte is lost or repeated
`include "assert_macros.svh"

module c_comment_stripper (
   input  logic          clock,
   input  logic          reset,
   ccs_req_if.sink       req_chan,
   ccs_rsp_if.source     rsp_chan
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eot_ff, in_eot_in;

   // lexer state
   ccs_pkg::mode_type      mode_ff, mode_in, mode_nxt;
   ccs_pkg::lookahead_type la_ff, la_in, la_nxt;

   ccs_pkg::wr_type wr;
   logic            room;
   logic            fire;
   logic            req_xfer;

   // lexer state views for the checks below
   logic            lex_idle;
   logic            in_code;
   logic            in_comment;

   // the stage advances when the queue can take two bytes
   assign fire           = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || fire;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign in_byte_in  = req_xfer ? req_chan.in_byte : in_byte_ff;
   assign in_eot_in   = req_xfer ? req_chan.end_of_text : in_eot_ff;

   // lexer state only moves when an item leaves the stage
   assign mode_in = fire ? mode_nxt : mode_ff;
   assign la_in   = fire ? la_nxt : la_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= ccs_pkg::MODE_CODE;
         la_ff       <= ccs_pkg::LA_NONE;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         la_ff       <= la_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eot_ff  <= in_eot_in;
   end

   ccs_step u_step (
      .mode_i (mode_ff),
      .la_i   (la_ff),
      .byte_i (in_byte_ff),
      .eot_i  (in_eot_ff),
      .mode_o (mode_nxt),
      .la_o   (la_nxt),
      .wr_o   (wr)
   );

   ccs_out_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fire),
      .wr       (wr),
      .room     (room),
      .rd_valid (rsp_chan.valid),
      .rd_ready (rsp_chan.ready),
      .rd_data  (rsp_chan.out_byte),
      .rd_last  (rsp_chan.last_of_run)
   );

   assign lex_idle   = (mode_ff == ccs_pkg::MODE_CODE) && (la_ff == ccs_pkg::LA_NONE);
   assign in_code    = (mode_ff == ccs_pkg::MODE_CODE);
   assign in_comment = (mode_ff == ccs_pkg::MODE_COMMENT);

   // end of text always leaves code mode with nothing pending
   `CCS_ASSERT_NEXT(a_eot_clears, clock, reset, fire && in_eot_ff, lex_idle)
   // a pending slash only arises in code, a pending star only in a comment
   `CCS_ASSERT_IMPL(a_slash_in_code, clock, reset, la_ff == ccs_pkg::LA_SLASH, in_code)
   `CCS_ASSERT_IMPL(a_star_in_comment, clock, reset, la_ff == ccs_pkg::LA_STAR, in_comment)

endmodule
